FILE: design/sfmr_pkg.sv
`timescale 1ns / 1ps

package sfmr_pkg;

  localparam int PATTERN_MAX     = 8;
  localparam int REPLACEMENT_MAX = 8;
  localparam int WIN_DEPTH       = PATTERN_MAX - 1;
  localparam int BATCH_MAX       = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_PATTERN_BYTES      = 3'd1,
    REG_REPLACEMENT_LENGTH = 3'd2,
    REG_REPLACEMENT_BYTES  = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       line_end;
  } item_t;

  // effective (saturated) configuration seen by the datapath
  typedef struct packed {
    logic [3:0]  plen;
    logic [63:0] pat;
    logic [3:0]  rlen;
    logic [63:0] repl;
  } cfg_t;

  // all result items caused by one request
  typedef struct packed {
    logic [BATCH_MAX-1:0][7:0] bytes;
    logic [3:0]                count;
    logic                      bare;
    logic                      line_end;
  } batch_t;

  function automatic logic [3:0] eff_plen(input logic [3:0] len);
    logic [3:0] r;
    r = len;
    if (len == 4'd0) r = 4'd1;
    else if (len > 4'(PATTERN_MAX)) r = 4'(PATTERN_MAX);
    return r;
  endfunction

  function automatic logic [3:0] eff_rlen(input logic [3:0] len);
    logic [3:0] r;
    r = len;
    if (len > 4'(REPLACEMENT_MAX)) r = 4'(REPLACEMENT_MAX);
    return r;
  endfunction

endpackage

FILE: design/sfmr_in_skid.sv
`timescale 1ns / 1ps

module sfmr_in_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sfmr_pkg::item_t in_item,
  input  logic            take,
  output logic            p_valid,
  output sfmr_pkg::item_t p_item
);
  import sfmr_pkg::*;

  logic  p_valid_r, s_valid_r;
  item_t p_r, s_r;
  logic  in_fire, p_free;

  assign in_ready = !s_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign p_free   = !p_valid_r || take;
  assign p_valid  = p_valid_r;
  assign p_item   = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else if (p_free) begin
      if (s_valid_r) begin
        p_valid_r <= 1'b1;
        s_valid_r <= 1'b0;
      end else begin
        p_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      s_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p_free) begin
      p_r <= s_valid_r ? s_r : in_item;
    end else if (in_fire) begin
      s_r <= in_item;
    end
  end

  // skid slot only fills behind an occupied main slot
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |-> p_valid_r)
    else $error("skid entry without main entry");

endmodule

FILE: design/sfmr_core.sv
`timescale 1ns / 1ps

module sfmr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfmr_pkg::item_t  item,
  input  sfmr_pkg::cfg_t   cfg,
  output sfmr_pkg::batch_t batch
);
  import sfmr_pkg::*;

  logic [WIN_DEPTH-1:0][7:0] win_r, win_nxt;
  logic [2:0]                cnt_r, cnt_nxt;
  logic                      rep_r, rep_nxt;

  logic [BATCH_MAX-1:0][7:0] cand;
  logic [3:0]                n, s, e, k, drop;
  logic                      eq, hit;
  logic [63:0]               shifted;

  always_comb begin
    n = {1'b0, cnt_r} + 4'd1;

    // held bytes followed by the new one
    cand = '0;
    for (int i = 0; i < BATCH_MAX; i++) begin
      cand[i] = item.data;
    end
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (3'(i) < cnt_r) cand[i] = win_r[i];
    end

    eq = 1'b1;
    for (int i = 0; i < BATCH_MAX; i++) begin
      if (4'(i) < cfg.plen && cand[i] != cfg.pat[8*i +: 8]) eq = 1'b0;
    end
    hit  = !rep_r && (n == cfg.plen) && eq;
    drop = n - cfg.plen + 4'd1;

    // e: bytes emitted now, s: bytes removed from the window
    e = 4'd0;
    s = 4'd0;
    if (rep_r) begin
      e = n;
      s = n;
    end else if (n > cfg.plen) begin
      e = drop;
      s = drop;
    end else if (n == cfg.plen) begin
      if (hit) begin
        e = cfg.rlen;
        s = n;
      end else begin
        e = 4'd1;
        s = 4'd1;
      end
    end

    // at line end the whole window follows the emitted bytes
    k = (item.line_end && !hit) ? n : e;

    batch.line_end = item.line_end;
    batch.bare     = item.line_end && (k == 4'd0);
    batch.count    = batch.bare ? 4'd1 : k;
    if (batch.bare) batch.bytes = '0;
    else if (hit) batch.bytes = cfg.repl;
    else batch.bytes = cand;

    shifted = cand >> {s, 3'b000};
    win_nxt = shifted[WIN_DEPTH*8-1:0];
    cnt_nxt = 3'(n - s);
    rep_nxt = rep_r || hit;
    if (item.line_end) begin
      win_nxt = '0;
      cnt_nxt = 3'd0;
      rep_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= 3'd0;
      rep_r <= 1'b0;
    end else if (load) begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
      rep_r <= rep_nxt;
    end
  end

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load && item.line_end |=> cnt_r == 3'd0 && !rep_r)
    else $error("line state not cleared at line end");

  a_no_hold_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    rep_r |-> cnt_r == 3'd0)
    else $error("bytes held after the match");

endmodule

FILE: design/sfmr_out.sv
`timescale 1ns / 1ps

module sfmr_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfmr_pkg::batch_t batch,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_line_end
);
  import sfmr_pkg::*;

  logic [BATCH_MAX-1:0][7:0] bytes_r;
  logic [3:0]                cnt_r;
  logic                      bare_r, le_r;
  logic                      out_fire;

  assign out_valid      = cnt_r != 4'd0;
  assign out_fire       = out_valid && out_ready;
  assign free           = (cnt_r == 4'd0) || (cnt_r == 4'd1 && out_ready);
  assign out_byte       = bytes_r[0];
  assign out_byte_valid = !bare_r;
  assign out_line_end   = le_r && (cnt_r == 4'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else if (load) begin
      cnt_r <= batch.count;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= batch.bytes;
      bare_r  <= batch.bare;
      le_r    <= batch.line_end;
    end else if (out_fire) begin
      bytes_r <= bytes_r >> 8;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'(BATCH_MAX))
    else $error("result count overflow");

  a_bare_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bare_r |-> cnt_r == 4'd1 && le_r)
    else $error("bare marker not a lone line end");

endmodule

FILE: design/stream_first_match_replace.sv
`timescale 1ns / 1ps

// stream_first_match_replace
// Edits one line of text per pass: the leftmost occurrence of the pattern
// (1..8 bytes) is replaced by the replacement text (0..8 bytes); later bytes
// of the line pass through unchanged.
// Input channel: in_valid/in_ready with in_byte and in_line_end (last byte).
// Output channel: out_valid/out_ready with out_byte, out_byte_valid and
// out_line_end. A line whose end yields no character gets a bare marker
// (out_byte_valid low, out_line_end high).
// Configuration: cfg_we/cfg_index/cfg_wdata, written while the block is idle.
// Requests are registered in the input buffer, results in the output buffer.
// Throughput: one byte per cycle while out_ready is high; a request that yields k results
// holds the output buffer until all k are taken (a replacement burst or a line-end flush of up
// to 8 bytes), and the input side stalls once its two-entry buffer is full.
// Up to pattern length minus one bytes are held back until they are decided.
// in_ready comes from a register, so no path runs from out_ready to in_ready.
// Reset (synchronous, rst_n low) clears the line state and both buffers and
// sets pattern length 1, all other configuration registers zero.
// A stalled receiver simply holds the current result; nothing is dropped.
module stream_first_match_replace (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  input  logic                               in_line_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_byte_valid,
  output logic                               out_line_end,
  input  logic                               cfg_we,
  input  logic [sfmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfmr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sfmr_pkg::*;

  // configuration registers
  logic [3:0]  plen_r, rlen_r;
  logic [63:0] pat_r, repl_r;
  cfg_t        cfg;

  item_t  in_item, p_item;
  logic   p_valid, out_free, load;
  batch_t batch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= 4'd1;
      pat_r  <= '0;
      rlen_r <= 4'd0;
      repl_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH:     plen_r <= cfg_wdata[3:0];
        REG_PATTERN_BYTES:      pat_r  <= cfg_wdata;
        REG_REPLACEMENT_LENGTH: rlen_r <= cfg_wdata[3:0];
        REG_REPLACEMENT_BYTES:  repl_r <= cfg_wdata;
        default: ;  // unknown index: write ignored
      endcase
    end
  end

  // saturate lengths once, ahead of the datapath
  assign cfg.plen = eff_plen(plen_r);
  assign cfg.pat  = pat_r;
  assign cfg.rlen = eff_rlen(rlen_r);
  assign cfg.repl = repl_r;

  assign in_item.data     = in_byte;
  assign in_item.line_end = in_line_end;

  // a held request moves on when the output buffer can take its results
  assign load = p_valid && out_free;

  sfmr_in_skid u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (load),
    .p_valid  (p_valid),
    .p_item   (p_item)
  );

  sfmr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .item  (p_item),
    .cfg   (cfg),
    .batch (batch)
  );

  sfmr_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .batch          (batch),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_line_end   (out_line_end)
  );

  a_bare_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0 && out_line_end)
    else $error("bare marker carries data");

endmodule
